// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, masked while reset is asserted.
`define DSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dsparse_pkg.sv =====
// ---------------------------------------------------------------------------
// dsparse_pkg
// Types, constants and the unit-letter decoder of the duration parser.
// ---------------------------------------------------------------------------
package dsparse_pkg;

	localparam int unsigned VAL_W   = 31;
	localparam int unsigned SCALE_W = 17;

	localparam logic [VAL_W-1:0]   SAT_MAX      = '1;
	localparam logic [SCALE_W-1:0] SCALE_SEC    = 17'd1;
	localparam logic [SCALE_W-1:0] SCALE_MIN    = 17'd60;
	localparam logic [SCALE_W-1:0] SCALE_HOUR   = 17'd3600;
	localparam logic [SCALE_W-1:0] SCALE_DAY    = 17'd86400;
	localparam logic [7:0]         DIGIT_ZERO   = 8'h30;
	localparam logic [7:0]         DIGIT_NINE   = 8'h39;

	localparam logic [7:0] CH_S_LO = 8'h73;
	localparam logic [7:0] CH_S_UP = 8'h53;
	localparam logic [7:0] CH_M_LO = 8'h6D;
	localparam logic [7:0] CH_M_UP = 8'h4D;
	localparam logic [7:0] CH_H_LO = 8'h68;
	localparam logic [7:0] CH_H_UP = 8'h48;
	localparam logic [7:0] CH_D_LO = 8'h64;
	localparam logic [7:0] CH_D_UP = 8'h44;

	typedef struct packed {
		logic [VAL_W-1:0] number;
		logic [VAL_W-1:0] total;
		logic             bad;
		logic             ovf;
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] total;
		logic             bad;
		logic             ovf;
	} result_t;

	typedef struct packed {
		logic               hit;
		logic [SCALE_W-1:0] scale;
	} unit_t;

	function automatic unit_t unit_decode(input logic [7:0] c);
		unit_t u;
		u.hit = 1'b1;
		unique case (c) inside
			CH_S_LO, CH_S_UP: u.scale = SCALE_SEC;
			CH_M_LO, CH_M_UP: u.scale = SCALE_MIN;
			CH_H_LO, CH_H_UP: u.scale = SCALE_HOUR;
			CH_D_LO, CH_D_UP: u.scale = SCALE_DAY;
			default: begin
				u.hit   = 1'b0;
				u.scale = '0;
			end
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/dsparse_step.sv =====
// ---------------------------------------------------------------------------
// dsparse_step
// Next-state and result logic for one character or end item.
// ---------------------------------------------------------------------------
module dsparse_step import dsparse_pkg::*; (
	input  logic       is_end,
	input  logic [7:0] char_code,
	input  state_t     cur,
	output state_t     nxt,
	output result_t    res
);

	localparam int unsigned NUM_W = VAL_W + 4;
	localparam int unsigned SUM_W = VAL_W + SCALE_W + 1;

	logic               is_digit;
	logic [3:0]         dval;
	logic [NUM_W-1:0]   num_wide;
	logic               num_sat;
	unit_t              ud;
	logic [SCALE_W-1:0] scale;
	logic [SUM_W-1:0]   sum;
	logic               sum_sat;
	logic [VAL_W-1:0]   sum_clip;

	assign is_digit = (char_code >= DIGIT_ZERO) && (char_code <= DIGIT_NINE);
	assign dval     = 4'(char_code - DIGIT_ZERO);
	assign num_wide = NUM_W'(cur.number) * NUM_W'(10) + NUM_W'(dval);
	assign num_sat  = num_wide > NUM_W'(SAT_MAX);

	assign ud       = unit_decode(char_code);
	// end item flushes pending digits as seconds
	assign scale    = is_end ? SCALE_SEC : ud.scale;
	assign sum      = SUM_W'(cur.total) + SUM_W'(cur.number) * SUM_W'(scale);
	assign sum_sat  = sum > SUM_W'(SAT_MAX);
	assign sum_clip = sum_sat ? SAT_MAX : sum[VAL_W-1:0];

	always_comb begin
		nxt       = cur;
		res.bad   = cur.bad;
		res.ovf   = cur.ovf | (~cur.bad & sum_sat);
		res.total = cur.bad ? '0 : sum_clip;
		if (is_end) begin
			nxt = '0;
		end else if (!cur.bad) begin
			if (is_digit) begin
				nxt.number = num_sat ? SAT_MAX : num_wide[VAL_W-1:0];
				nxt.ovf    = cur.ovf | num_sat;
			end else if (ud.hit) begin
				nxt.total  = sum_clip;
				nxt.number = '0;
				nxt.ovf    = cur.ovf | sum_sat;
			end else begin
				nxt.bad = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/duration_string_parser_core.sv =====
// ---------------------------------------------------------------------------
// duration_string_parser_core
// Parses duration text such as 3d4h10m5s, one character per transfer, and
// returns the total in seconds (saturating) on the end-of-text transfer.
// ---------------------------------------------------------------------------
//
//  channel  | direction | tdata                    | tuser / tlast
//  ---------+-----------+--------------------------+------------------------------
//  s_axis   | in        | [7:0] char_code          | tlast = op (1 = end of text)
//  m_axis   | out       | [30:0] total_seconds,    | tuser[0] bad_char,
//           |           | [31] zero                | tuser[1] overflowed
//
//  Rate: one transfer per cycle sustained, except while an end transfer
//  stalls. Each character updates the parse state in the single step
//  stage; the step holds a multiply by ten and a multiply by the unit scale
//  (31 x 17 bits), each with an add/compare; the wider one sets the cycle.
//  An end transfer passes the input stage, then the output register.
//  Reset clears the input stage, parse state and output valid.
//  Stalls: characters keep flowing while a result waits; only an end
//  transfer holds in the input stage until the output register is free.
// ---------------------------------------------------------------------------
module duration_string_parser_core import dsparse_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // op: end of text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [30:0] total_seconds, [31] zero
	output logic [1:0]  m_axis_tuser    // [0] bad_char, [1] overflowed
);

	// input stage
	logic       valid_s1;
	logic       last_s1;
	logic [7:0] char_s1;

	// parse state and output register
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    out_valid_q;

	logic stall_s1;
	logic advance_s1;

	// an end item needs the output register; characters in the input stage never wait
	assign stall_s1      = valid_s1 & last_s1 & out_valid_q & ~m_axis_tready;
	assign advance_s1    = valid_s1 & ~stall_s1;
	assign s_axis_tready = ~stall_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			last_s1 <= s_axis_tlast;
			char_s1 <= s_axis_tdata;
		end
	end

	dsparse_step u_step (
		.is_end    (last_s1),
		.char_code (char_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, res_q.total};
	assign m_axis_tuser  = {res_q.ovf, res_q.bad};

endmodule

// ===== rtl/dsparse_checker.sv =====
// ---------------------------------------------------------------------------
// dsparse_checker
// Port-level checks for duration_string_parser_core, attached by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dsparse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic unused_in;
	assign unused_in = s_axis_tvalid ^ s_axis_tready ^ (^s_axis_tdata) ^ s_axis_tlast;

	`DSP_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	`DSP_ASSERT(a_bad_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0, "bad text must report zero total")
	`DSP_ASSERT(a_pad_bit, m_axis_tvalid |-> !m_axis_tdata[31], "total exceeds 31 bits")
	`DSP_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind duration_string_parser_core dsparse_checker u_dsparse_checker (.*);
